[design/simple_risc_instruction_executor_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the simple RISC executor
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SIMPLE_RISC_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define SIMPLE_RISC_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SRE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRE_ASSERT_IMPL(label, ante, cons, msg)
`define SRE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/sre_pkg.sv]
// ---------------------------------------------------------------------------
// sre_pkg
// Shared types and constants of the simple RISC executor.
// ---------------------------------------------------------------------------
package sre_pkg;

	localparam int unsigned OPCODE_MAX = 21;
	localparam logic [3:0] IO_RETURN_INDEX = 4'd7;
	// data memory words, one per 12-bit address
	localparam int DATA_DEPTH = 4096;

	typedef enum logic [7:0] {
		OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MAC = 8'd2, OP_AND = 8'd3,
		OP_OR = 8'd4, OP_XOR = 8'd5, OP_SLL = 8'd6, OP_SRA = 8'd7,
		OP_SRL = 8'd8, OP_BEQ = 8'd9, OP_BNE = 8'd10, OP_BLT = 8'd11,
		OP_BGT = 8'd12, OP_BLE = 8'd13, OP_BGE = 8'd14, OP_JAL = 8'd15,
		OP_LW = 8'd16, OP_SW = 8'd17, OP_RETI = 8'd18, OP_IN = 8'd19,
		OP_OUT = 8'd20, OP_HALT = 8'd21
	} opcode_t;

	typedef enum logic [1:0] {
		IO_NONE = 2'd0, IO_READ = 2'd1, IO_WRITE = 2'd2
	} io_kind_t;

	// decoded word handed from front to back
	typedef struct packed {
		logic        preload;
		logic        bad;
		logic [7:0]  op;
		logic [3:0]  rd;
		logic [3:0]  rs;
		logic [3:0]  rt;
		logic [3:0]  rm;
		logic [31:0] imm1;
		logic [31:0] imm2;
		logic [11:0] load_addr;
		logic [31:0] load_data;
	} dec_t;

	function automatic logic [31:0] sext12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

endpackage

[design/sre_ram.sv]
// ---------------------------------------------------------------------------
// sre_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module sre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[design/sre_front.sv]
// ---------------------------------------------------------------------------
// sre_front
// Accept words, decode fields and hold them in a two-entry queue.
// ---------------------------------------------------------------------------
`include "simple_risc_instruction_executor_assert.svh"
module sre_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           req_type,
	input  logic [47:0]    instruction,
	input  logic [11:0]    load_addr,
	input  logic [31:0]    load_data,
	output logic           dq_valid,
	input  logic           dq_ready,
	output sre_pkg::dec_t  dq_word
);
	import sre_pkg::*;

	dec_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	dec_t       dec;
	logic       push, pop;

	always_comb begin
		dec.preload   = req_type;
		dec.op        = instruction[47:40];
		dec.bad       = !req_type && (instruction[47:40] > 8'(OPCODE_MAX));
		dec.rd        = instruction[39:36];
		dec.rs        = instruction[35:32];
		dec.rt        = instruction[31:28];
		dec.rm        = instruction[27:24];
		dec.imm1      = sext12(instruction[23:12]);
		dec.imm2      = sext12(instruction[11:0]);
		dec.load_addr = load_addr;
		dec.load_data = load_data;
	end

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign dq_valid = cnt_q != 2'd0;
	assign pop      = dq_valid && dq_ready;
	assign dq_word  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`SRE_ASSERT_IMPL(a_no_overflow, cnt_q == 2'd2, !push, "queue push while full")
	`SRE_ASSERT_NEXT(a_cnt_up, push && !pop && cnt_q == 2'd0, cnt_q == 2'd1,
		"queue count lost a push")
	`SRE_ASSERT_IMPL(a_valid_cnt, dq_valid, cnt_q != 2'd0, "queue valid while empty")
endmodule

[design/sre_back.sv]
// ---------------------------------------------------------------------------
// sre_back
// Execute decoded words: register file, data memory, I/O store, pc.
// ---------------------------------------------------------------------------
`include "simple_risc_instruction_executor_assert.svh"
module sre_back #(
	parameter int IO_COUNT   = 23
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          dq_valid,
	output logic          dq_ready,
	input  sre_pkg::dec_t dq_word,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [11:0]   next_pc,
	output logic          halted,
	output logic          bad_opcode,
	output logic [1:0]    io_kind,
	output logic [4:0]    io_index,
	output logic [31:0]   io_value
);
	import sre_pkg::*;

	localparam int AW = $clog2(DATA_DEPTH);

	typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_LOAD} st_t;

	st_t          st_q, st_d;
	logic [AW:0]  clr_q;
	logic [11:0]  pc_q;
	logic [31:0]  rf_q [16];
	logic [31:0]  io_q [IO_COUNT];
	logic [31:0]  prod_s1;
	dec_t         ld_q;

	logic         ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]  ram_wdata, ram_rdata;

	sre_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	function automatic logic [31:0] rd_reg(input logic [3:0] i, input dec_t w,
		input logic [31:0] rf [16]);
		logic [31:0] v;
		case (i)
			4'd0:    v = '0;
			4'd1:    v = w.imm1;
			4'd2:    v = w.imm2;
			default: v = rf[i];
		endcase
		return v;
	endfunction

	logic [31:0] a, b, c, e, sum_ab, res;
	logic [4:0]  sh;
	logic        take, wr_rd, out_full_q, fire, mac_wait_q;
	logic [11:0] npc;
	logic [1:0]  kind;
	logic [4:0]  idx;
	logic [31:0] ival;
	logic        io_ok;
	logic        lt_ab, lt_ba;

	always_comb begin
		a      = rd_reg(dq_word.rs, dq_word, rf_q);
		b      = rd_reg(dq_word.rt, dq_word, rf_q);
		c      = rd_reg(dq_word.rm, dq_word, rf_q);
		e      = rd_reg(dq_word.rd, dq_word, rf_q);
		sum_ab = a + b;
		sh     = b[4:0];
		lt_ab  = $signed(a) < $signed(b);
		lt_ba  = $signed(b) < $signed(a);
		io_ok  = sum_ab < 32'(IO_COUNT);
	end

	// output register, takes a new word when empty or being drained
	logic out_free;
	assign out_free = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_comb begin
		st_d     = st_q;
		dq_ready = 1'b0;
		fire     = 1'b0;
		ram_we   = 1'b0;
		ram_addr = sum_ab[AW-1:0];
		ram_wdata = c + e;
		res      = '0;
		wr_rd    = 1'b0;
		take     = 1'b0;
		npc      = pc_q + 12'd1;
		kind     = IO_NONE;
		idx      = '0;
		ival     = '0;
		unique case (st_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q[AW-1:0];
				ram_wdata = '0;
				if (clr_q == (AW+1)'(DATA_DEPTH - 1))
					st_d = ST_RUN;
			end
			ST_LOAD: begin
				res   = ram_rdata + rd_reg(ld_q.rm, ld_q, rf_q);
				wr_rd = 1'b1;
				if (out_free) begin
					fire = 1'b1;
					st_d = ST_RUN;
				end
			end
			default: begin
				if (dq_valid && out_free) begin
					if (dq_word.preload) begin
						ram_we    = 1'b1;
						ram_addr  = dq_word.load_addr[AW-1:0];
						ram_wdata = dq_word.load_data;
						npc       = pc_q;
						dq_ready  = 1'b1;
						fire      = 1'b1;
					end else if (dq_word.bad) begin
						npc      = pc_q;
						dq_ready = 1'b1;
						fire     = 1'b1;
					end else begin
						dq_ready = 1'b1;
						fire     = 1'b1;
						case (dq_word.op)
							OP_ADD: begin res = a + b + c; wr_rd = 1'b1; end
							OP_SUB: begin res = a - b - c; wr_rd = 1'b1; end
							OP_MAC: begin
								// product registered, sum added next cycle
								dq_ready = mac_wait_q;
								fire     = mac_wait_q;
								res      = prod_s1 + c;
								wr_rd    = mac_wait_q;
							end
							OP_AND: begin res = a & b & c; wr_rd = 1'b1; end
							OP_OR:  begin res = a | b | c; wr_rd = 1'b1; end
							OP_XOR: begin res = a ^ b ^ c; wr_rd = 1'b1; end
							OP_SLL: begin res = a << sh; wr_rd = 1'b1; end
							OP_SRA: begin res = 32'($signed(a) >>> sh); wr_rd = 1'b1; end
							OP_SRL: begin res = a >> sh; wr_rd = 1'b1; end
							OP_BEQ: take = a == b;
							OP_BNE: take = a != b;
							OP_BLT: take = lt_ab;
							OP_BGT: take = lt_ba;
							OP_BLE: take = !lt_ba;
							OP_BGE: take = !lt_ab;
							OP_JAL: begin
								res   = 32'(pc_q + 12'd1);
								wr_rd = 1'b1;
								npc   = (dq_word.rd == dq_word.rm) ? pc_q + 12'd1 : c[11:0];
							end
							OP_LW: begin
								dq_ready = 1'b1;
								fire     = 1'b0;
								st_d     = ST_LOAD;
							end
							OP_SW: ram_we = 1'b1;
							OP_RETI: npc = io_q[IO_RETURN_INDEX][11:0];
							OP_IN: if (io_ok) begin
								kind  = IO_READ;
								idx   = sum_ab[4:0];
								ival  = io_q[sum_ab[4:0]];
								res   = ival;
								wr_rd = 1'b1;
							end
							OP_OUT: if (io_ok) begin
								kind = IO_WRITE;
								idx  = sum_ab[4:0];
								ival = c;
							end
							default: npc = pc_q;
						endcase
						if (take)
							npc = c[11:0];
					end
				end
			end
		endcase
	end

	logic [3:0] wr_idx;
	assign wr_idx = (st_q == ST_LOAD) ? ld_q.rd : dq_word.rd;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (st_q == ST_RUN && dq_ready)
			ld_q <= dq_word;
		if (fire) begin
			next_pc    <= (st_q == ST_LOAD) ? pc_q + 12'd1 : npc;
			halted     <= st_q == ST_RUN && !dq_word.preload && !dq_word.bad &&
				dq_word.op == OP_HALT;
			bad_opcode <= st_q == ST_RUN && dq_word.bad;
			io_kind    <= kind;
			io_index   <= idx;
			io_value   <= ival;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			pc_q       <= '0;
			out_full_q <= 1'b0;
			mac_wait_q <= 1'b0;
			for (int i = 0; i < 16; i++)
				rf_q[i] <= '0;
			for (int i = 0; i < IO_COUNT; i++)
				io_q[i] <= '0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_q + 1'b1;
			if (fire)
				out_full_q <= 1'b1;
			else if (out_ready)
				out_full_q <= 1'b0;
			mac_wait_q <= st_q == ST_RUN && dq_valid && out_free && !dq_word.preload &&
				!dq_word.bad && dq_word.op == OP_MAC && !mac_wait_q;
			if (fire)
				pc_q <= (st_q == ST_LOAD) ? pc_q + 12'd1 : npc;
			if (wr_rd && (fire) && wr_idx > 4'd2)
				rf_q[wr_idx] <= res;
			if (fire && st_q == ST_RUN && kind == IO_WRITE)
				io_q[idx] <= ival;
		end
	end

	`SRE_ASSERT_IMPL(a_clear_idle, st_q == ST_CLEAR, !fire && !dq_ready,
		"word taken during memory clear")
	`SRE_ASSERT_NEXT(a_load_next, st_q == ST_RUN && st_d == ST_LOAD, !dq_ready,
		"load second cycle took a new word")
	`SRE_ASSERT_IMPL(a_fire_room, fire, out_free, "result overwrote a held word")
endmodule

[design/simple_risc_instruction_executor.sv]
// ---------------------------------------------------------------------------
// simple_risc_instruction_executor
// 48-bit instruction executor with decoupled decode queue and execute unit.
// ---------------------------------------------------------------------------
// channel   | signals                   | contents
// s_axis    | tvalid tready tdata tuser | instruction word or preload word
// m_axis    | tvalid tready tdata       | next pc, flags and I/O access
//
// One word per cycle for most opcodes while the output register is free; mac
// and lw hold the next word back behind a registered step (the registered
// multiplier and the synchronous data memory read). After reset the data memory
// is swept to zero, during which nothing executes and the queue takes at most
// two words. A two-entry queue parts decode from execute; the output register
// takes the next result in the same cycle the held one drains.
// ---------------------------------------------------------------------------
`include "simple_risc_instruction_executor_assert.svh"
module simple_risc_instruction_executor #(
	parameter int IO_COUNT   = 23
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: instruction[47:0], load_addr[59:48], load_data[91:60], zero[95:92]
	input  logic [95:0]  s_axis_tdata,
	// tuser: req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: next_pc[11:0], halted[12], bad_opcode[13], io_kind[15:14],
	// io_index[20:16], io_value[52:21], zero[55:53]
	output logic [55:0]  m_axis_tdata
);
	import sre_pkg::*;

	logic  dq_valid, dq_ready;
	dec_t  dq_word;
	logic [11:0] next_pc;
	logic        halted, bad_opcode;
	logic [1:0]  io_kind;
	logic [4:0]  io_index;
	logic [31:0] io_value;

	// front: accept and decode
	sre_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.req_type(s_axis_tuser), .instruction(s_axis_tdata[47:0]),
		.load_addr(s_axis_tdata[59:48]), .load_data(s_axis_tdata[91:60]),
		.dq_valid(dq_valid), .dq_ready(dq_ready), .dq_word(dq_word)
	);

	// back: execute and hold the result
	sre_back #(.IO_COUNT(IO_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.dq_valid(dq_valid), .dq_ready(dq_ready), .dq_word(dq_word),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.next_pc(next_pc), .halted(halted), .bad_opcode(bad_opcode),
		.io_kind(io_kind), .io_index(io_index), .io_value(io_value)
	);

	assign m_axis_tdata = {3'b000, io_value, io_index, io_kind, bad_opcode, halted, next_pc};
endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for the simple RISC instruction executor
// Drives instruction and preload words over the input stream, predicts the
// next pc, flags and I/O access of each word, and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import sre_pkg::*;

	localparam int DEPTH = 4096;
	localparam int IO_N  = 23;

	// lowest field last, matching the result tdata layout
	typedef struct packed {
		logic [31:0] io_value;
		logic [4:0]  io_index;
		logic [1:0]  io_kind;
		logic        bad_opcode;
		logic        halted;
		logic [11:0] next_pc;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	// predictor state
	logic [11:0] pc_q;
	logic [31:0] regs_q [16];
	logic [31:0] dmem_q [DEPTH];
	logic [31:0] io_q [IO_N];

	outcome_t expected_q[$];
	int       fail_count = 0;

	simple_risc_instruction_executor u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] widen12(logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	// Compute the outcome of one word and advance the predictor state.
	function automatic outcome_t execute_word(logic preload, logic [47:0] inst,
			logic [11:0] addr, logic [31:0] data);
		outcome_t o;
		logic [7:0] op;
		logic [3:0] rd, rs, rt, rm;
		logic [4:0] sh;
		logic [31:0] a;
		logic take;
		logic [11:0] nxt;
		o = '0;
		take = 1'b0;
		nxt = pc_q + 12'd1;
		op = inst[47:40]; rd = inst[39:36]; rs = inst[35:32];
		rt = inst[31:28]; rm = inst[27:24];
		if (preload) begin
			dmem_q[addr % DEPTH] = data;
			nxt = pc_q;
		end else if (op > OPCODE_MAX) begin
			o.bad_opcode = 1'b1;
			nxt = pc_q;
		end else begin
			regs_q[0] = '0;
			regs_q[1] = widen12(inst[23:12]);
			regs_q[2] = widen12(inst[11:0]);
			sh = regs_q[rt][4:0];
			a = regs_q[rs] + regs_q[rt];
			case (opcode_t'(op))
				OP_ADD: regs_q[rd] = regs_q[rs] + regs_q[rt] + regs_q[rm];
				OP_SUB: regs_q[rd] = regs_q[rs] - regs_q[rt] - regs_q[rm];
				OP_MAC: regs_q[rd] = regs_q[rs] * regs_q[rt] + regs_q[rm];
				OP_AND: regs_q[rd] = regs_q[rs] & regs_q[rt] & regs_q[rm];
				OP_OR:  regs_q[rd] = regs_q[rs] | regs_q[rt] | regs_q[rm];
				OP_XOR: regs_q[rd] = regs_q[rs] ^ regs_q[rt] ^ regs_q[rm];
				OP_SLL: regs_q[rd] = regs_q[rs] << sh;
				OP_SRA: regs_q[rd] = $unsigned($signed(regs_q[rs]) >>> sh);
				OP_SRL: regs_q[rd] = regs_q[rs] >> sh;
				OP_BEQ: take = regs_q[rs] == regs_q[rt];
				OP_BNE: take = regs_q[rs] != regs_q[rt];
				OP_BLT: take = $signed(regs_q[rs]) < $signed(regs_q[rt]);
				OP_BGT: take = $signed(regs_q[rs]) > $signed(regs_q[rt]);
				OP_BLE: take = $signed(regs_q[rs]) <= $signed(regs_q[rt]);
				OP_BGE: take = $signed(regs_q[rs]) >= $signed(regs_q[rt]);
				OP_JAL: begin
					regs_q[rd] = {20'd0, pc_q + 12'd1};
					nxt = regs_q[rm][11:0];
				end
				OP_LW: regs_q[rd] = dmem_q[a[11:0] % DEPTH] + regs_q[rm];
				OP_SW: dmem_q[a[11:0] % DEPTH] = regs_q[rm] + regs_q[rd];
				OP_RETI: nxt = io_q[IO_RETURN_INDEX][11:0];
				OP_IN: if (a < IO_N) begin
					o.io_value = io_q[a];
					regs_q[rd] = io_q[a];
					o.io_kind = IO_READ;
					o.io_index = a[4:0];
				end
				OP_OUT: if (a < IO_N) begin
					o.io_value = regs_q[rm];
					io_q[a] = regs_q[rm];
					o.io_kind = IO_WRITE;
					o.io_index = a[4:0];
				end
				default: begin
					o.halted = 1'b1;
					nxt = pc_q;
				end
			endcase
			if (take)
				nxt = regs_q[rm][11:0];
			regs_q[0] = '0;
		end
		pc_q = nxt;
		o.next_pc = nxt;
		return o;
	endfunction

	// Send one word after a random gap; hold it until accepted.
	task automatic send_word(logic preload, logic [47:0] inst,
			logic [11:0] addr, logic [31:0] data);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= preload;
		s_axis_tdata <= {4'd0, data, addr, inst};
		expected_q.push_back(execute_word(preload, inst, addr, data));
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [47:0] make_inst(logic [7:0] op, logic [3:0] rd,
			logic [3:0] rs, logic [3:0] rt, logic [3:0] rm, logic [11:0] i1,
			logic [11:0] i2);
		return {op, rd, rs, rt, rm, i1, i2};
	endfunction

	// Random operand register, mostly the immediates or a few low registers.
	function automatic logic [3:0] pick_reg();
		return ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, 5));
	endfunction

	// Accept results with random stalls and compare them field by field.
	initial begin : result_check
		outcome_t got, want;
		int stall;
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			got = m_axis_tdata[52:0];
			if (expected_q.size() == 0) begin
				$error("result with no expected word: %h", got);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (got.next_pc !== want.next_pc) begin
					$error("next_pc expected %h actual %h", want.next_pc, got.next_pc);
					fail_count++;
				end
				if (got.halted !== want.halted) begin
					$error("halted expected %b actual %b", want.halted, got.halted);
					fail_count++;
				end
				if (got.bad_opcode !== want.bad_opcode) begin
					$error("bad_opcode expected %b actual %b", want.bad_opcode,
						got.bad_opcode);
					fail_count++;
				end
				if (got.io_kind !== want.io_kind) begin
					$error("io_kind expected %d actual %d", want.io_kind, got.io_kind);
					fail_count++;
				end
				if (got.io_index !== want.io_index) begin
					$error("io_index expected %d actual %d", want.io_index, got.io_index);
					fail_count++;
				end
				if (got.io_value !== want.io_value) begin
					$error("io_value expected %h actual %h", want.io_value, got.io_value);
					fail_count++;
				end
			end
		end
	end

	// Drop the input and wait until every expected result has come.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Every opcode once with extreme immediates, plus the named corner cases.
	task automatic test_directed();
		send_word(1'b1, '1, 12'hfff, 32'h8000_0000);
		send_word(1'b1, '0, 12'h000, 32'h7fff_ffff);
		send_word(1'b0, make_inst(OP_ADD, 4'd3, 4'd1, 4'd2, 4'd0, 12'h7ff, 12'h800), 0, 0);
		send_word(1'b0, make_inst(OP_SUB, 4'd4, 4'd1, 4'd2, 4'd3, 12'h800, 12'h7ff), 0, 0);
		send_word(1'b0, make_inst(OP_MAC, 4'd5, 4'd1, 4'd2, 4'd3, 12'hfff, 12'h123), 0, 0);
		send_word(1'b0, make_inst(OP_AND, 4'd6, 4'd1, 4'd2, 4'd5, 12'hfff, 12'hf0f), 0, 0);
		send_word(1'b0, make_inst(OP_OR, 4'd7, 4'd1, 4'd2, 4'd4, 12'h00f, 12'h0f0), 0, 0);
		send_word(1'b0, make_inst(OP_XOR, 4'd8, 4'd1, 4'd2, 4'd7, 12'haaa, 12'h555), 0, 0);
		// shift amounts use the low five bits only
		send_word(1'b0, make_inst(OP_SLL, 4'd9, 4'd1, 4'd2, 4'd0, 12'h801, 12'h03f), 0, 0);
		send_word(1'b0, make_inst(OP_SRA, 4'd10, 4'd1, 4'd2, 4'd0, 12'h800, 12'h01f), 0, 0);
		send_word(1'b0, make_inst(OP_SRL, 4'd11, 4'd1, 4'd2, 4'd0, 12'h800, 12'h000), 0, 0);
		send_word(1'b0, make_inst(OP_BEQ, 4'd0, 4'd1, 4'd2, 4'd1, 12'h010, 12'h010), 0, 0);
		send_word(1'b0, make_inst(OP_BNE, 4'd0, 4'd1, 4'd2, 4'd2, 12'h010, 12'h020), 0, 0);
		send_word(1'b0, make_inst(OP_BLT, 4'd0, 4'd1, 4'd2, 4'd2, 12'h800, 12'h7ff), 0, 0);
		send_word(1'b0, make_inst(OP_BGT, 4'd0, 4'd1, 4'd2, 4'd1, 12'h7ff, 12'h800), 0, 0);
		send_word(1'b0, make_inst(OP_BLE, 4'd0, 4'd1, 4'd2, 4'd1, 12'h005, 12'h005), 0, 0);
		send_word(1'b0, make_inst(OP_BGE, 4'd0, 4'd1, 4'd2, 4'd2, 12'h004, 12'h005), 0, 0);
		// jal with rd equal to rm targets pc+1
		send_word(1'b0, make_inst(OP_JAL, 4'd12, 4'd0, 4'd0, 4'd12, 12'h0, 12'h0), 0, 0);
		send_word(1'b0, make_inst(OP_SW, 4'd1, 4'd2, 4'd0, 4'd2, 12'h001, 12'hfff), 0, 0);
		send_word(1'b0, make_inst(OP_LW, 4'd13, 4'd2, 4'd0, 4'd1, 12'h001, 12'hfff), 0, 0);
		send_word(1'b0, make_inst(OP_OUT, 4'd0, 4'd1, 4'd2, 4'd1, 12'h7ff, 12'h808), 0, 0);
		send_word(1'b0, make_inst(OP_IN, 4'd14, 4'd1, 4'd2, 4'd0, 12'h016, 12'h000), 0, 0);
		// index out of range, negative sum
		send_word(1'b0, make_inst(OP_IN, 4'd14, 4'd1, 4'd0, 4'd0, 12'hfff, 12'h000), 0, 0);
		send_word(1'b0, make_inst(OP_RETI, 4'd0, 4'd0, 4'd0, 4'd0, 12'h0, 12'h0), 0, 0);
		send_word(1'b0, make_inst(OP_HALT, 4'd0, 4'd0, 4'd0, 4'd0, 12'h0, 12'h0), 0, 0);
		send_word(1'b0, make_inst(8'hff, 4'hf, 4'hf, 4'hf, 4'hf, 12'hfff, 12'hfff), 0, 0);
	endtask

	// Mostly valid opcodes, often with small I/O operands; some noise.
	task automatic test_random(int count);
		logic [47:0] inst;
		logic [7:0] op;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2)
				wait_drained();
			case ($urandom_range(0, 19))
				0: send_word(1'b1, 48'({$urandom, $urandom}), 12'($urandom),
					$urandom);
				1: send_word(1'b0, 48'({$urandom, $urandom}), 12'($urandom), $urandom);
				default: begin
					op = 8'($urandom_range(0, OPCODE_MAX));
					inst = make_inst(op, pick_reg(), pick_reg(), pick_reg(),
						pick_reg(), 12'($urandom), 12'($urandom));
					if ((op == OP_IN || op == OP_OUT) && $urandom_range(0, 1))
						inst[23:0] = {12'($urandom_range(0, 11)),
							12'($urandom_range(0, 11))};
					send_word(1'b0, inst, 12'($urandom), $urandom);
				end
			endcase
		end
	endtask

	initial begin : run
		pc_q = '0;
		foreach (regs_q[i]) regs_q[i] = '0;
		foreach (dmem_q[i]) dmem_q[i] = '0;
		foreach (io_q[i]) io_q[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(400);
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("simple_risc_instruction_executor test passed");
		else
			$display("simple_risc_instruction_executor test failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("simple_risc_instruction_executor test failed");
		$finish;
	end

endmodule
